>>> rtl/core/vfbc_pkg.sv
`timescale 1ns / 1ps
package vfbc_pkg;

	// Lanes that convert; lane slots at or past this count give zero.
	localparam int LANES    = 3;
	localparam int MAX_LANE = 3;

	typedef enum logic [1:0] {
		FN_F2U = 2'd0,
		FN_U2F = 2'd1,
		FN_F2S = 2'd2,
		FN_S2F = 2'd3
	} func_t;

	// Significands of single-precision 1/255 and 1/127
	localparam logic [23:0] UNORM_RCP = 24'h808081;
	localparam logic [23:0] SNORM_RCP = 24'h810204;
	localparam logic [7:0]  UNORM_SCL = 8'd255;
	localparam logic [7:0]  SNORM_SCL = 8'd127;
	localparam logic [7:0]  EXP_MAX   = 8'hFF;

	typedef struct packed {
		logic [31:0] fval;
		logic [7:0]  bval;
	} lane_res_t;

endpackage

>>> rtl/core/vfbc_lane.sv
`timescale 1ns / 1ps
module vfbc_lane import vfbc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  func_t       func,
	input  logic [31:0] f_bits,
	input  logic [7:0]  b_in,
	output lane_res_t   res
);

	// Stage 1: unpack and multiply (float to byte)
	logic [31:0] fp_prod_s1;
	logic [7:0]  fp_exp_s1;
	logic        fp_sgn_s1;
	logic        fp_nan_s1;
	logic        fp_inf_s1;
	logic        fp_zero_s1;
	logic        snorm_s1;
	// Stage 1: normalize and multiply (byte to float)
	logic [31:0] bp_prod_s1;
	logic [2:0]  bp_lz_s1;
	logic        bp_sgn_s1;
	logic        bp_zero_s1;

	logic [31:0] fp_prod;
	logic [31:0] bp_prod;
	logic [7:0]  b_mag;
	logic [7:0]  b_norm;
	logic [2:0]  b_lz;
	logic        b_sgn;

	always_comb begin
		logic found;
		fp_prod = {8'd0, 1'b1, f_bits[22:0]} *
			{24'd0, (func[1] ? SNORM_SCL : UNORM_SCL)};
		b_sgn = func[1] & b_in[7];
		b_mag = b_sgn ? 8'(-b_in) : b_in;
		b_lz  = 3'd0;
		found = 1'b0;
		for (int k = 7; k >= 0; k--) begin
			if (!found && b_mag[k]) begin
				b_lz  = 3'(7 - k);
				found = 1'b1;
			end
		end
		b_norm  = b_mag << b_lz;
		bp_prod = {24'd0, b_norm} * {8'd0, (func[1] ? SNORM_RCP : UNORM_RCP)};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fp_prod_s1 <= fp_prod;
			fp_exp_s1  <= f_bits[30:23];
			fp_sgn_s1  <= f_bits[31];
			fp_nan_s1  <= (f_bits[30:23] == EXP_MAX) && (f_bits[22:0] != 23'd0);
			fp_inf_s1  <= (f_bits[30:23] == EXP_MAX) && (f_bits[22:0] == 23'd0);
			fp_zero_s1 <= (f_bits[30:23] == 8'd0);
			snorm_s1   <= func[1];
			bp_prod_s1 <= bp_prod;
			bp_lz_s1   <= b_lz;
			bp_sgn_s1  <= b_sgn;
			bp_zero_s1 <= (b_mag == 8'd0);
		end
	end

	// Stage 2: round to single, truncate and clamp
	always_comb begin
		logic [1:0]        sh;
		logic [31:0]       pn;
		logic signed [9:0] ue;
		logic              up;
		logic [24:0]       r25;
		logic [24:0]       mag;
		logic [4:0]        rs;
		logic [7:0]        lim;
		logic [7:0]        m;
		logic              big;
		logic              bs;
		logic [31:0]       bn;
		logic [8:0]        bexp;
		logic [24:0]       br;
		logic              bup;

		// float to byte
		if (fp_prod_s1[31])      sh = 2'd0;
		else if (fp_prod_s1[30]) sh = 2'd1;
		else                     sh = 2'd2;
		pn  = fp_prod_s1 << sh;
		ue  = $signed({2'b00, fp_exp_s1}) - 10'sd119 - $signed({8'd0, sh});
		up  = pn[7] & ((|pn[6:0]) | pn[8]);
		r25 = {1'b0, pn[31:8]} + 25'(up);
		lim = snorm_s1 ? SNORM_SCL : UNORM_SCL;
		mag = 25'd0;
		big = 1'b0;
		rs  = 5'd0;
		if (ue > 10'sd8) begin
			big = 1'b1;
		end else if (ue >= -10'sd1) begin
			rs  = 5'(10'sd23 - ue);
			mag = r25 >> rs;
		end
		if (fp_nan_s1 || fp_zero_s1)
			m = 8'd0;
		else if (fp_inf_s1 || big || (mag > {17'd0, lim}))
			m = lim;
		else
			m = mag[7:0];
		if (snorm_s1)
			res.bval = fp_sgn_s1 ? 8'(-m) : m;
		else
			res.bval = fp_sgn_s1 ? 8'd0 : m;

		// byte to float
		bs   = ~bp_prod_s1[31];
		bn   = bp_prod_s1 << bs;
		bup  = bn[7] & ((|bn[6:0]) | bn[8]);
		br   = {1'b0, bn[31:8]} + 25'(bup);
		bexp = (snorm_s1 ? 9'd128 : 9'd127) - {8'd0, bs} - {6'd0, bp_lz_s1};
		if (bp_zero_s1)
			res.fval = 32'd0;
		else if (br[24])
			res.fval = {bp_sgn_s1, 8'(bexp + 9'd1), 23'd0};
		else
			res.fval = {bp_sgn_s1, bexp[7:0], br[22:0]};
	end

endmodule

>>> rtl/core/vec3_float_byte_convert.sv
`timescale 1ns / 1ps
// Throughput: one request per clock; lane multipliers and the output
// register are fully pipelined, so only a stalled result holds the pipe.
// Reset: arst_n clears the valid flags of both stages; payload registers
// are not reset. The block keeps no other state.
module vec3_float_byte_convert import vfbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  func,
	input  logic [31:0] x_bits,
	input  logic [31:0] y_bits,
	input  logic [31:0] z_bits,
	input  logic [7:0]  in_byte_0,
	input  logic [7:0]  in_byte_1,
	input  logic [7:0]  in_byte_2,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] out_float_0,
	output logic [31:0] out_float_1,
	output logic [31:0] out_float_2,
	output logic [7:0]  out_byte_0,
	output logic [7:0]  out_byte_1,
	output logic [7:0]  out_byte_2
);

	// Whole pipe advances together unless a finished result is held.
	logic adv;
	logic vld_s1;
	logic vld_s2;
	func_t func_s1;

	logic [31:0] f_in  [MAX_LANE];
	logic [7:0]  b_in  [MAX_LANE];
	lane_res_t   l_res [MAX_LANE];
	logic [31:0] fo_s2 [MAX_LANE];
	logic [7:0]  bo_s2 [MAX_LANE];

	assign adv       = !vld_s2 || !res_stall;
	assign req_stall = !adv;
	assign res_valid = vld_s2;

	assign f_in[0] = x_bits;
	assign f_in[1] = y_bits;
	assign f_in[2] = z_bits;
	assign b_in[0] = in_byte_0;
	assign b_in[1] = in_byte_1;
	assign b_in[2] = in_byte_2;

	// Valid flags: advance on every free cycle, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			func_s1 <= func_t'(func);
	end

	// One conversion lane per component; slots past LANES give zero.
	for (genvar i = 0; i < MAX_LANE; i++) begin : g_lane
		if (i < LANES) begin : g_on
			vfbc_lane u_lane (
				.clk    (clk),
				.en     (adv),
				.func   (func_t'(func)),
				.f_bits (f_in[i]),
				.b_in   (b_in[i]),
				.res    (l_res[i])
			);
		end else begin : g_off
			assign l_res[i] = '0;
		end

		// Merge: keep the field the mode produces, drop the other to zero.
		always_ff @(posedge clk) begin
			if (adv) begin
				case (func_s1)
					FN_F2U, FN_F2S: begin
						fo_s2[i] <= 32'd0;
						bo_s2[i] <= l_res[i].bval;
					end
					FN_U2F, FN_S2F: begin
						fo_s2[i] <= l_res[i].fval;
						bo_s2[i] <= 8'd0;
					end
					default: begin
						fo_s2[i] <= 32'd0;
						bo_s2[i] <= 8'd0;
					end
				endcase
			end
		end
	end

	assign out_float_0 = fo_s2[0];
	assign out_float_1 = fo_s2[1];
	assign out_float_2 = fo_s2[2];
	assign out_byte_0  = bo_s2[0];
	assign out_byte_1  = bo_s2[1];
	assign out_byte_2  = bo_s2[2];

endmodule
